>>> sv/pht_pkg.sv
// ----------------------------------------------------------------------------
// pht_pkg
// Shared types, constants and helpers for the potentiometer conditioning block.
// ----------------------------------------------------------------------------
package pht_pkg;

    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned POS_W     = 16;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 12;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_BAND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAKEOVER_BAND   = 2'd2;

    // Register reset values
    localparam logic [COUNT_W-1:0]  RESET_COUNT      = 4'd8;
    localparam logic [SAMPLE_W-1:0] RESET_HYSTERESIS = 12'd6;
    localparam logic [SAMPLE_W-1:0] RESET_TAKEOVER   = 12'd64;

    // Input modes
    localparam logic MODE_UPDATE     = 1'b0;
    localparam logic MODE_REBASELINE = 1'b1;

    // Position scaling: floor((held - 16) * 65535 / 4063) between the end zones
    localparam logic [SAMPLE_W-1:0] ZONE_SIZE  = 12'd16;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [SAMPLE_W-1:0] HIGH_ZONE  = FULL_SCALE - ZONE_SIZE;
    localparam logic [POS_W-1:0]    POS_MAX    = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] POS_SPAN   = FULL_SCALE - 12'd2 * ZONE_SIZE;

    // Reciprocal multiply: exact for every held offset up to 4062
    localparam int unsigned SCALE_SHIFT = 25;
    localparam int unsigned SCALE_MUL_W = 30;
    localparam int unsigned PROD_W      = SAMPLE_W + SCALE_MUL_W;
    localparam logic [63:0] SCALE_NUM   = 64'(POS_MAX) << SCALE_SHIFT;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL =
        SCALE_MUL_W'((SCALE_NUM + 64'(POS_SPAN) - 64'd1) / 64'(POS_SPAN));

    // One channel entry in the state memory
    typedef struct packed {
        logic [SAMPLE_W-1:0] held;
        logic [SAMPLE_W-1:0] base;
        logic                primed;
        logic                moved;
    } entry_t;

    function automatic logic [SAMPLE_W-1:0] abs_diff(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> sv/pht_ram.sv
// ----------------------------------------------------------------------------
// pht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pht_ram #(
    parameter int unsigned WIDTH = 26,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/pht_scale.sv
// ----------------------------------------------------------------------------
// pht_scale
// Held value to 16-bit position: end zones plus reciprocal multiply, one stage.
// ----------------------------------------------------------------------------
module pht_scale
    import pht_pkg::*;
(
    input  logic                aclk,
    input  logic                load,
    input  logic [SAMPLE_W-1:0] held,
    output logic [POS_W-1:0]    position
);

    logic [SAMPLE_W-1:0] offset;
    logic [PROD_W-1:0]   prod_reg;
    logic                low_reg;
    logic                high_reg;

    // Offset wraps below the low zone; the zone flags mask it.
    assign offset = held - ZONE_SIZE;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= PROD_W'(offset) * PROD_W'(SCALE_MUL);
            low_reg  <= (held <= ZONE_SIZE);
            high_reg <= (held >= HIGH_ZONE);
        end
    end

    always_comb begin
        if (low_reg) begin
            position = '0;
        end else if (high_reg) begin
            position = POS_MAX;
        end else begin
            position = prod_reg[SCALE_SHIFT+POS_W-1:SCALE_SHIFT];
        end
    end

endmodule

>>> sv/pot_hysteresis_takeover.sv
// Sequence: an in-range sample is read, modified and written back, multiplied,
//   then loaded into the output register, which waits for a free output slot;
//   the next request is taken after that load. Out-of-range: output load only.
// Rebaseline: next request taken once every active channel is written back.
// Reset (synchronous, active low): registers return to 8 / 6 / 64 and every
//   channel's valid bit clears, so all entries read as zero; no clearing pass.
// ----------------------------------------------------------------------------
// pot_hysteresis_takeover
// Per-channel potentiometer conditioning with hysteresis and soft takeover.
// ----------------------------------------------------------------------------
module pot_hysteresis_takeover
    import pht_pkg::*;
#(
    parameter int unsigned CHANNELS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,

    // sample requests
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [CH_W-1:0]      s_channel,
    input  logic [SAMPLE_W-1:0]  s_raw_sample,

    // results
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CH_W-1:0]      m_channel_echo,
    output logic [POS_W-1:0]     m_position,
    output logic                 m_moved_flag,
    output logic                 m_in_range
);

    localparam int unsigned AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned CNT_W = $clog2(CHANNELS + 1);
    localparam int unsigned ENT_W = $bits(entry_t);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_MUL  = 5'b00100,
        S_EMIT = 5'b01000,
        S_RB   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [COUNT_W-1:0]  count_cfg_reg;
    logic [SAMPLE_W-1:0] hyst_cfg_reg;
    logic [SAMPLE_W-1:0] tko_cfg_reg;

    // request being worked on
    logic [CH_W-1:0]     ch_reg;
    logic [SAMPLE_W-1:0] raw_reg;
    logic                oor_reg;
    logic [SAMPLE_W-1:0] held_reg;
    logic                moved_reg;

    // rebaseline sweep
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rb_pend_reg;
    logic [AW-1:0]    rb_addr_reg;

    // per-entry valid bits: an entry never written reads as zero
    logic [CHANNELS-1:0] vld_reg;
    logic                rd_vld_reg;

    // output register
    logic                m_valid_reg;
    logic [CH_W-1:0]     m_channel_echo_reg;
    logic [POS_W-1:0]    m_position_reg;
    logic                m_moved_flag_reg;
    logic                m_in_range_reg;

    // memory ports
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [ENT_W-1:0] ram_rdata;
    entry_t           ram_wdata;
    entry_t           cur;

    logic [CNT_W-1:0]    count_eff;
    logic                s_acc;
    logic                s_in_range;
    logic                rb_issue;
    logic                out_free;
    logic [POS_W-1:0]    scale_pos;
    logic [SAMPLE_W-1:0] held_n;
    logic [SAMPLE_W-1:0] base_n;
    logic                moved_n;

    // Clamp the active count to the number of channels built.
    assign count_eff = ({4'b0, count_cfg_reg} > CH_W'(CHANNELS)) ?
                       CNT_W'(CHANNELS) : CNT_W'(count_cfg_reg);

    assign s_ready    = (state_reg == S_IDLE);
    assign s_acc      = s_valid && s_ready;
    assign s_in_range = (s_channel < {{(CH_W-CNT_W){1'b0}}, count_eff});
    assign out_free   = !m_valid_reg || m_ready;
    assign rb_issue   = (state_reg == S_RB) && (idx_reg < count_eff);

    // Entry as read back, masked to zero until first written.
    assign cur = rd_vld_reg ? entry_t'(ram_rdata) : '0;

    // Update rule: first sample primes; later ones follow past the hysteresis
    // band, and moved sticks once held leaves the takeover band around baseline.
    always_comb begin
        if (!cur.primed) begin
            held_n  = raw_reg;
            base_n  = raw_reg;
            moved_n = 1'b0;
        end else begin
            held_n  = (abs_diff(raw_reg, cur.held) > hyst_cfg_reg) ? raw_reg : cur.held;
            base_n  = cur.base;
            moved_n = cur.moved || (abs_diff(held_n, cur.base) > tko_cfg_reg);
        end
    end

    // Memory access: read on acceptance of an in-range update or during the sweep,
    // write back in the next cycle. Only one request is in flight, so accesses never collide.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = s_channel[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = ch_reg[AW-1:0];
        ram_wdata = '{held: held_n, base: base_n, primed: 1'b1, moved: moved_n};
        case (state_reg)
            S_IDLE: begin
                ram_re = s_acc && (s_mode == MODE_UPDATE) && s_in_range;
            end
            S_MOD: begin
                ram_we = 1'b1;
            end
            S_RB: begin
                ram_re    = rb_issue;
                ram_raddr = idx_reg[AW-1:0];
                ram_we    = rb_pend_reg;
                ram_waddr = rb_addr_reg;
                ram_wdata = '{held: cur.held, base: cur.held, primed: cur.primed,
                              moved: 1'b0};
            end
            default: begin
            end
        endcase
    end

    pht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pht_scale u_scale (
        .aclk     (aclk),
        .load     (state_reg == S_MUL),
        .held     (held_reg),
        .position (scale_pos)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_mode == MODE_REBASELINE) begin
                        state_next = S_RB;
                        idx_next   = '0;
                    end else if (s_in_range) begin
                        state_next = S_MOD;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_MOD: begin
                state_next = S_MUL;
            end
            S_MUL: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_RB: begin
                if (rb_issue) begin
                    idx_next = idx_reg + 1'b1;
                end else if (!rb_pend_reg) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_cfg_reg <= RESET_COUNT;
            hyst_cfg_reg  <= RESET_HYSTERESIS;
            tko_cfg_reg   <= RESET_TAKEOVER;
            vld_reg       <= '0;
            rb_pend_reg   <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rb_pend_reg <= rb_issue;

            if (cfg_we) begin
                case (cfg_addr)
                    REG_CHANNEL_COUNT:   count_cfg_reg <= cfg_wdata[COUNT_W-1:0];
                    REG_HYSTERESIS_BAND: hyst_cfg_reg  <= cfg_wdata;
                    REG_TAKEOVER_BAND:   tko_cfg_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (ram_we) begin
                vld_reg[ram_waddr] <= 1'b1;
            end

            // load a new result into a free slot, else drop the one taken
            if ((state_reg == S_EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers: no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            ch_reg  <= s_channel;
            raw_reg <= s_raw_sample;
            oor_reg <= !s_in_range;
        end
        if (ram_re) begin
            rd_vld_reg <= vld_reg[ram_raddr];
        end
        if (rb_issue) begin
            rb_addr_reg <= idx_reg[AW-1:0];
        end
        if (state_reg == S_MOD) begin
            held_reg  <= held_n;
            moved_reg <= moved_n;
        end
        if ((state_reg == S_EMIT) && out_free) begin
            m_channel_echo_reg <= ch_reg;
            m_position_reg     <= oor_reg ? '0 : scale_pos;
            m_moved_flag_reg   <= oor_reg ? 1'b0 : moved_reg;
            m_in_range_reg     <= !oor_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_channel_echo = m_channel_echo_reg;
    assign m_position     = m_position_reg;
    assign m_moved_flag   = m_moved_flag_reg;
    assign m_in_range     = m_in_range_reg;

endmodule

>>> sv/pht_checker.sv
// ----------------------------------------------------------------------------
// pht_checker
// Port-level checks for pot_hysteresis_takeover, bound to the top level.
// ----------------------------------------------------------------------------
module pht_checker
    import pht_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CH_W-1:0]   m_channel_echo,
    input logic [POS_W-1:0]  m_position,
    input logic              m_moved_flag,
    input logic              m_in_range
);

    // no result is offered right after reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one request at a time: the input closes right after an acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // an out-of-range result carries zeros
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> (m_position == '0) && !m_moved_flag)
        else $error("out-of-range result not zero");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_channel_echo)
            && $stable(m_position) && $stable(m_moved_flag) && $stable(m_in_range))
        else $error("stalled result changed");

endmodule

bind pot_hysteresis_takeover pht_checker u_pht_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_channel_echo (m_channel_echo),
    .m_position     (m_position),
    .m_moved_flag   (m_moved_flag),
    .m_in_range     (m_in_range)
);

>>> tb/pot_takeover_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_takeover_sb_pkg
// Scoreboard for the potentiometer conditioning block. Keeps its own copy of
// the per-channel held, baseline, primed and moved state and checks reports in
// the order the requests were taken.
// ----------------------------------------------------------------------------
package pot_takeover_sb_pkg;
    import pht_pkg::*;

    localparam int unsigned NUM_CHANNELS = 8;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [POS_W-1:0] position;
        logic             moved;
        logic             in_range;
    } pot_report_t;

    class pot_takeover_scoreboard;
        logic [COUNT_W-1:0]  chan_count;
        logic [SAMPLE_W-1:0] hyst_band;
        logic [SAMPLE_W-1:0] takeover_band;
        entry_t              chan_state [NUM_CHANNELS];
        pot_report_t         pending_reports [$];
        int unsigned         mismatches;

        function new();
            chan_count    = RESET_COUNT;
            hyst_band     = RESET_HYSTERESIS;
            takeover_band = RESET_TAKEOVER;
            foreach (chan_state[i]) chan_state[i] = '0;
            mismatches    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_CHANNEL_COUNT:   chan_count    = data[COUNT_W-1:0];
                REG_HYSTERESIS_BAND: hyst_band     = data[SAMPLE_W-1:0];
                REG_TAKEOVER_BAND:   takeover_band = data[SAMPLE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned active_channels();
            return (chan_count > NUM_CHANNELS) ? NUM_CHANNELS : chan_count;
        endfunction

        function int unsigned spread(int unsigned a, int unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        // Clamp the end zones, scale the middle to the full 16-bit range
        function logic [POS_W-1:0] scaled_position(logic [SAMPLE_W-1:0] held);
            int unsigned offset;
            if (held <= ZONE_SIZE) return '0;
            if (held >= HIGH_ZONE) return POS_MAX;
            offset = 32'(held - ZONE_SIZE);
            return POS_W'((offset * 32'(POS_MAX)) / 32'(POS_SPAN));
        endfunction

        // Advance the state for one taken request and queue the report it causes
        function void note_request(logic mode, logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] raw);
            pot_report_t rep;
            entry_t      e;
            int unsigned n;
            n = active_channels();
            if (mode == MODE_REBASELINE) begin
                for (int unsigned i = 0; i < n; i++) begin
                    chan_state[i].base  = chan_state[i].held;
                    chan_state[i].moved = 1'b0;
                end
                return;
            end
            rep = '0;
            rep.channel = ch;
            if (ch < n) begin
                e = chan_state[ch];
                if (!e.primed) begin
                    e.held   = raw;
                    e.base   = raw;
                    e.primed = 1'b1;
                    e.moved  = 1'b0;
                end else begin
                    if (spread(raw, e.held) > hyst_band) e.held = raw;
                    if (!e.moved && spread(e.held, e.base) > takeover_band) e.moved = 1'b1;
                end
                chan_state[ch] = e;
                rep.position = scaled_position(e.held);
                rep.moved    = e.moved;
                rep.in_range = 1'b1;
            end
            pending_reports.push_back(rep);
        endfunction

        function void compare_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(pot_report_t got);
            pot_report_t want;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report: expected none, actual channel %0d pos %0d",
                         $time, got.channel, got.position);
                mismatches++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("channel_echo", POS_W'(want.channel), POS_W'(got.channel));
            compare_field("position", want.position, got.position);
            compare_field("moved_flag", POS_W'(want.moved), POS_W'(got.moved));
            compare_field("in_range", POS_W'(want.in_range), POS_W'(got.in_range));
        endfunction

        function int unsigned outstanding();
            return pending_reports.size();
        endfunction
    endclass

endpackage

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample and rebaseline requests into the potentiometer conditioning
// block under several register settings and idle patterns, and checks every
// report against the scoreboard's own prediction of held value and takeover.
// ----------------------------------------------------------------------------
module testbench;
    import pht_pkg::*;
    import pot_takeover_sb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    // Rebaseline walks every active channel with no report; cover it and more
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_DAT_W-1:0] cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_mode;
    logic [CH_W-1:0]      s_channel;
    logic [SAMPLE_W-1:0]  s_raw_sample;
    logic                 m_valid;
    logic                 m_ready;
    logic [CH_W-1:0]      m_channel_echo;
    logic [POS_W-1:0]     m_position;
    logic                 m_moved_flag;
    logic                 m_in_range;

    pot_takeover_scoreboard board = new();

    int unsigned requests_taken = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Last sample sent per channel slot, so random samples can wander nearby
    logic [SAMPLE_W-1:0] last_raw [NUM_CHANNELS];

    pot_hysteresis_takeover DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stall the result side at random; the percentage changes per phase
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sample both handshakes at the rising edge, feed the scoreboard and
    // watch for a stuck block.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_request(s_mode, s_channel, s_raw_sample);
            requests_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            board.check_result('{m_channel_echo, m_position, m_moved_flag, m_in_range});
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Write one register; hold the enable for exactly one edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        board.write_register(idx, data);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input logic [CFG_DAT_W-1:0] count, input logic [CFG_DAT_W-1:0] hyst,
                             input logic [CFG_DAT_W-1:0] takeover);
        write_reg(REG_CHANNEL_COUNT, count);
        write_reg(REG_HYSTERESIS_BAND, hyst);
        write_reg(REG_TAKEOVER_BAND, takeover);
    endtask

    // Send one request. Called at a falling edge; returns at the falling edge
    // after the request is taken, with valid still high so a back-to-back
    // request can follow without a gap.
    task automatic send_request(input logic mode, input logic [CH_W-1:0] ch,
                                input logic [SAMPLE_W-1:0] raw);
        int unsigned seen;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_channel    <= ch;
        s_raw_sample <= raw;
        seen = requests_taken;
        do @(negedge aclk); while (requests_taken == seen);
    endtask

    // Drop valid, wait for every report, then let a trailing rebaseline finish
    task automatic drain_reports();
        s_valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Mostly drift near the last sample to work the hysteresis and takeover
    // bands; also full-range jumps and the end-zone borders.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [2:0] slot);
        int unsigned roll;
        int unsigned step;
        int          level;
        roll = $urandom_range(99);
        if (roll < 50) begin
            step  = $urandom_range(0, 2 * board.hyst_band + 8);
            level = $urandom_range(1) ? int'(last_raw[slot]) + int'(step)
                                      : int'(last_raw[slot]) - int'(step);
            if (level < 0) level = 0;
            if (level > int'(FULL_SCALE)) level = int'(FULL_SCALE);
            return SAMPLE_W'(level);
        end
        if (roll < 80) return SAMPLE_W'($urandom_range(4095));
        case ($urandom_range(5))
            0:       return '0;
            1:       return FULL_SCALE;
            2:       return ZONE_SIZE;
            3:       return ZONE_SIZE + 1'b1;
            4:       return HIGH_ZONE - 1'b1;
            default: return HIGH_ZONE;
        endcase
    endfunction

    task automatic run_random(input int unsigned items, input bit pause_midway);
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] raw;
        int unsigned         roll;
        for (int unsigned k = 0; k < items; k++) begin
            // Hold off the sender until the block has emptied out
            if (pause_midway && k == items / 2) drain_reports();
            roll = $urandom_range(99);
            if (roll < 4) begin
                send_request(MODE_REBASELINE, CH_W'($urandom), SAMPLE_W'($urandom));
            end else begin
                // Mostly channels near the active range, some anywhere in 0..255
                ch  = (roll < 12) ? CH_W'($urandom) : CH_W'($urandom_range(9));
                raw = pick_sample(ch[2:0]);
                send_request(MODE_UPDATE, ch, raw);
                last_raw[ch[2:0]] = raw;
            end
        end
        drain_reports();
    endtask

    // Directed requests at the reset settings (8 channels, band 6, takeover 64)
    task automatic run_directed();
        // first sample on each channel, end zones and their borders
        send_request(MODE_UPDATE, 8'd0, 12'd0);
        send_request(MODE_UPDATE, 8'd1, 12'd4095);
        send_request(MODE_UPDATE, 8'd2, 12'd16);
        send_request(MODE_UPDATE, 8'd3, 12'd17);
        send_request(MODE_UPDATE, 8'd4, 12'd4078);
        send_request(MODE_UPDATE, 8'd5, 12'd4079);
        send_request(MODE_UPDATE, 8'd6, 12'hAAA);
        send_request(MODE_UPDATE, 8'd7, 12'h555);
        // change equal to the band: held stays; one more: held follows
        send_request(MODE_UPDATE, 8'd0, 12'd6);
        send_request(MODE_UPDATE, 8'd0, 12'd7);
        // drift past the takeover band, then back: moved stays set
        send_request(MODE_UPDATE, 8'd0, 12'd71);
        send_request(MODE_UPDATE, 8'd0, 12'd0);
        // channels out of range report zeros
        send_request(MODE_UPDATE, 8'd8, 12'd100);
        send_request(MODE_UPDATE, 8'hFF, 12'hFFF);
        send_request(MODE_UPDATE, 8'hAA, 12'h555);
        send_request(MODE_UPDATE, 8'h55, 12'hAAA);
        // rebaseline clears moved; channel and sample are ignored
        send_request(MODE_REBASELINE, 8'hFF, 12'hFFF);
        send_request(MODE_UPDATE, 8'd0, 12'd0);
        send_request(MODE_UPDATE, 8'd1, 12'd4030);
        send_request(MODE_UPDATE, 8'd1, 12'd4031);
        drain_reports();

        // no active channels: everything out of range, rebaseline touches nothing
        write_reg(REG_CHANNEL_COUNT, 12'd0);
        send_request(MODE_UPDATE, 8'd0, 12'd50);
        send_request(MODE_REBASELINE, 8'd0, 12'd0);
        drain_reports();

        // count above the channel total acts as the total
        write_reg(REG_CHANNEL_COUNT, 12'd15);
        send_request(MODE_UPDATE, 8'd7, 12'd4095);
        send_request(MODE_UPDATE, 8'd8, 12'd2000);
        drain_reports();
    endtask

    initial begin
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_addr     <= '0;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_mode       <= MODE_UPDATE;
        s_channel    <= '0;
        s_raw_sample <= '0;
        foreach (last_raw[i]) last_raw[i] = '0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();

        // Phase 1: no idling; upper bits of the count write are dropped
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(12'hFF8, 12'(RESET_HYSTERESIS), 12'(RESET_TAKEOVER));
        run_random(160, 1'b0);

        // Phase 2: sender idles; zero bands make every change count
        send_idle_pct  = 47;
        recv_stall_pct = 0;
        configure(12'h00F, 12'd0, 12'd0);
        run_random(160, 1'b1);

        // Phase 3: receiver stalls; widest bands, three channels active
        send_idle_pct  = 0;
        recv_stall_pct = 47;
        configure(12'd3, 12'hFFF, 12'hFFF);
        run_random(160, 1'b0);

        // Phase 4: both sides idle; random settings and a write to no register
        send_idle_pct  = 23;
        recv_stall_pct = 23;
        configure(12'($urandom_range(1, 8)) | (12'($urandom) & 12'hFF0),
                  12'($urandom_range(40)), 12'($urandom_range(200)));
        write_reg(REG_UNMAPPED, 12'($urandom));
        run_random(170, 1'b0);

        if (board.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
sv/pht_pkg.sv
sv/pht_ram.sv
sv/pht_scale.sv
sv/pot_hysteresis_takeover.sv
sv/pht_checker.sv
tb/pot_takeover_sb_pkg.sv
tb/testbench.sv
